/* sv/sfd_pkg.sv */
// Shared types and constants for the serial frame deframer.
`default_nettype none

package sfd_pkg;

    // Result fields are fixed by the output item.
    localparam int OUT_PAY  = 8;
    localparam int LANE_W   = 3;
    localparam int CNT_W    = 5;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Register map, byte address 4*index.
    localparam logic [1:0] REG_HDR1    = 2'd0;
    localparam logic [1:0] REG_HDR2    = 2'd1;
    localparam logic [1:0] REG_LEN_MIN = 2'd2;
    localparam logic [1:0] REG_LEN_MAX = 2'd3;

    localparam logic [7:0] RST_HDR1    = 8'd170;
    localparam logic [7:0] RST_HDR2    = 8'd85;
    localparam logic [3:0] RST_LEN_MIN = 4'd2;
    localparam logic [3:0] RST_LEN_MAX = 4'd9;
    localparam logic [3:0] LEN_FLOOR   = 4'd2;

    typedef enum logic [2:0] {
        POS_HUNT,
        POS_HDR2,
        POS_LENH,
        POS_LENL,
        POS_DATA
    } t_pos;

    typedef struct packed {
        logic [7:0] hdr1;
        logic [7:0] hdr2;
        logic [3:0] len_min;
        logic [3:0] len_max;
    } t_cfg;

    // Frame completion, issued with the checksum byte.
    typedef struct packed {
        logic             valid;
        logic             sum_ok;
        logic [CNT_W-1:0] cnt;
        logic             slot;
    } t_emit;

    // Payload byte write into one lane RAM.
    typedef struct packed {
        logic              en;
        logic              slot;
        logic [LANE_W-1:0] lane;
        logic [7:0]        data;
    } t_wr;

endpackage

`default_nettype wire

/* sv/sfd_if.sv */
// Valid/ready channel interfaces for received bytes and frame results.
`default_nettype none

interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] payload_count;
    logic       sum_ok;
    logic [7:0] pay0;
    logic [7:0] pay1;
    logic [7:0] pay2;
    logic [7:0] pay3;
    logic [7:0] pay4;
    logic [7:0] pay5;
    logic [7:0] pay6;
    logic [7:0] pay7;

    modport source (output valid, output payload_count, output sum_ok,
                    output pay0, output pay1, output pay2, output pay3,
                    output pay4, output pay5, output pay6, output pay7,
                    input ready);
    modport sink   (input valid, input payload_count, input sum_ok,
                    input pay0, input pay1, input pay2, input pay3,
                    input pay4, input pay5, input pay6, input pay7,
                    output ready);
endinterface

`default_nettype wire

/* sv/sfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/sfd_regs.sv */
// APB-style configuration registers of the deframer.
`default_nettype none

module sfd_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sfd_pkg::DATA_W-1:0] pwdata,
    output logic      [sfd_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output sfd_pkg::t_cfg                   o_cfg
);

    sfd_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr1    <= sfd_pkg::RST_HDR1;
            r_cfg.hdr2    <= sfd_pkg::RST_HDR2;
            r_cfg.len_min <= sfd_pkg::RST_LEN_MIN;
            r_cfg.len_max <= sfd_pkg::RST_LEN_MAX;
        end else if (w_wr) begin
            case (paddr[3:2])
                sfd_pkg::REG_HDR1:    r_cfg.hdr1    <= pwdata[7:0];
                sfd_pkg::REG_HDR2:    r_cfg.hdr2    <= pwdata[7:0];
                sfd_pkg::REG_LEN_MIN: r_cfg.len_min <= pwdata[3:0];
                sfd_pkg::REG_LEN_MAX: r_cfg.len_max <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sfd_pkg::REG_HDR1:    prdata = {24'd0, r_cfg.hdr1};
            sfd_pkg::REG_HDR2:    prdata = {24'd0, r_cfg.hdr2};
            sfd_pkg::REG_LEN_MIN: prdata = {28'd0, r_cfg.len_min};
            sfd_pkg::REG_LEN_MAX: prdata = {28'd0, r_cfg.len_max};
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* sv/sfd_parser.sv */
// Frame parser: header hunt, length check, checksum and payload lane writes.
`default_nettype none

module sfd_parser #(
    parameter int MAX_PAYLOAD = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sfd_pkg::t_cfg i_cfg,
    input  wire logic          i_take,
    input  wire logic [7:0]    i_byte,
    output sfd_pkg::t_emit     o_emit,
    output sfd_pkg::t_wr       o_wr
);

    localparam int LW     = $clog2(MAX_PAYLOAD + 2);
    localparam int CW     = $clog2(MAX_PAYLOAD + 1);
    localparam int HI_CAP = MAX_PAYLOAD + 1;

    sfd_pkg::t_pos r_pos, n_pos;
    logic [LW-1:0] r_left, n_left;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_len_hi, n_len_hi;
    logic [7:0]    r_sum, n_sum;
    logic          r_slot, n_slot;

    logic [3:0]    w_lo;
    logic [4:0]    w_hi;
    logic [LW-1:0] w_left_dec;
    logic          w_last;
    logic          w_bad_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= sfd_pkg::POS_HUNT;
            r_left   <= '0;
            r_cnt    <= '0;
            r_len_hi <= '0;
            r_sum    <= '0;
            r_slot   <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_left   <= n_left;
            r_cnt    <= n_cnt;
            r_len_hi <= n_len_hi;
            r_sum    <= n_sum;
            r_slot   <= n_slot;
        end
    end

    // effective length bounds: at least 2, at most MAX_PAYLOAD + 1
    assign w_lo = (i_cfg.len_min < sfd_pkg::LEN_FLOOR) ? sfd_pkg::LEN_FLOOR : i_cfg.len_min;
    assign w_hi = ({1'b0, i_cfg.len_max} > 5'(HI_CAP)) ? 5'(HI_CAP) : {1'b0, i_cfg.len_max};

    assign w_bad_len  = (r_len_hi != 8'd0) || (i_byte < {4'd0, w_lo})
                        || (i_byte > {3'd0, w_hi});
    assign w_left_dec = (r_left == '0) ? '0 : r_left - 1'b1;
    assign w_last     = (w_left_dec == '0) || (r_cnt >= CW'(MAX_PAYLOAD));

    always_comb begin
        n_pos    = r_pos;
        n_left   = r_left;
        n_cnt    = r_cnt;
        n_len_hi = r_len_hi;
        n_sum    = r_sum;
        n_slot   = r_slot;

        o_emit.valid  = 1'b0;
        o_emit.sum_ok = (i_byte == r_sum);
        o_emit.cnt    = sfd_pkg::CNT_W'(r_cnt);
        o_emit.slot   = r_slot;

        o_wr.en   = 1'b0;
        o_wr.slot = r_slot;
        o_wr.lane = sfd_pkg::LANE_W'(r_cnt);
        o_wr.data = i_byte;

        if (i_take) begin
            case (r_pos)
                sfd_pkg::POS_HUNT: begin
                    if (i_byte == i_cfg.hdr1) begin
                        n_pos = sfd_pkg::POS_HDR2;
                    end
                    n_left = '0;
                end
                sfd_pkg::POS_HDR2: begin
                    // a mismatching byte is not retried as a first header byte
                    n_pos = (i_byte == i_cfg.hdr2) ? sfd_pkg::POS_LENH : sfd_pkg::POS_HUNT;
                end
                sfd_pkg::POS_LENH: begin
                    n_len_hi = i_byte;
                    n_sum    = i_byte;
                    n_pos    = sfd_pkg::POS_LENL;
                end
                sfd_pkg::POS_LENL: begin
                    n_sum = r_sum + i_byte;
                    n_cnt = '0;
                    if (w_bad_len) begin
                        n_pos  = sfd_pkg::POS_HUNT;
                        n_left = '0;
                    end else begin
                        n_pos  = sfd_pkg::POS_DATA;
                        n_left = LW'(i_byte);
                    end
                end
                sfd_pkg::POS_DATA: begin
                    if (w_last) begin
                        o_emit.valid = 1'b1;
                        n_pos        = sfd_pkg::POS_HUNT;
                        n_left       = '0;
                        n_slot       = ~r_slot;
                    end else begin
                        o_wr.en = (5'(r_cnt) < 5'(sfd_pkg::OUT_PAY));
                        n_sum   = r_sum + i_byte;
                        n_cnt   = r_cnt + 1'b1;
                        n_left  = w_left_dec;
                    end
                end
                default: begin
                    n_pos = sfd_pkg::POS_HUNT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/serial_frame_deframer_sum8.sv */
// Top level of the header/length/checksum serial deframer with sum-8 check.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------
//  i_rx     | in  | valid/ready          | rx_byte[7:0]
//  o_res    | out | valid/ready          | payload_count, sum_ok, pay0..pay7
//  apb      | in  | psel/penable, pready | paddr[3:0], pwdata/prdata[31:0]
//
//  One byte item per cycle while i_rx.ready is high. The parser state
//  update is the only loop; payload bytes go into per-lane RAMs.
//  A result passes from its checksum byte through the lane RAM read into
//  the holding stage, then into the output register.
//  i_rx.ready drops only while a read result waits in the holding stage and
//  the output register is full and stalled.
//  Reset (sync, active low) clears parser state, config and valid bits; the
//  lane RAMs are not cleared, no sweep after reset.
`default_nettype none

module serial_frame_deframer_sum8 #(
    parameter int MAX_PAYLOAD = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    sfd_rx_if.sink                          i_rx,
    sfd_res_if.source                       o_res,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sfd_pkg::DATA_W-1:0] pwdata,
    output logic      [sfd_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    // lanes actually backed by storage; output has at most OUT_PAY fields
    localparam int NL = (MAX_PAYLOAD < sfd_pkg::OUT_PAY) ? MAX_PAYLOAD : sfd_pkg::OUT_PAY;

    sfd_pkg::t_cfg  w_cfg;
    sfd_pkg::t_emit w_emit;
    sfd_pkg::t_wr   w_wr;
    logic           w_take;
    logic           w_out_free;
    logic           w_s1_move;
    logic [7:0]     w_rdata [sfd_pkg::OUT_PAY];
    logic [7:0]     w_pay   [sfd_pkg::OUT_PAY];

    // holding stage: result waiting for lane RAM read data
    logic                      r_s1_valid;
    logic                      r_s1_ok;
    logic [sfd_pkg::CNT_W-1:0] r_s1_cnt;

    // output register
    logic                      r_o_valid;
    logic                      r_o_ok;
    logic [sfd_pkg::CNT_W-1:0] r_o_cnt;
    logic [7:0]                r_o_pay [sfd_pkg::OUT_PAY];

    sfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_out_free = !r_o_valid || o_res.ready;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign i_rx.ready = !r_s1_valid || w_out_free;
    assign w_take     = i_rx.valid && i_rx.ready;

    sfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_take  (w_take),
        .i_byte  (i_rx.rx_byte),
        .o_emit  (w_emit),
        .o_wr    (w_wr)
    );

    // One byte-wide RAM per stored payload lane (k < NL), two frame slots each;
    // the slot flips at every completed frame so the next frame never hits
    // the one being read.
    for (genvar k = 0; k < sfd_pkg::OUT_PAY; k++) begin : g_lane
        if (k < NL) begin : g_ram
            sfd_ram #(
                .WIDTH (8),
                .DEPTH (2)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (w_wr.en && (w_wr.lane == sfd_pkg::LANE_W'(k))),
                .i_waddr (w_wr.slot),
                .i_wdata (w_wr.data),
                .i_re    (w_take && w_emit.valid),
                .i_raddr (w_emit.slot),
                .o_rdata (w_rdata[k])
            );
        end else begin : g_none
            assign w_rdata[k] = 8'd0;
        end
        // bytes past the count read as zero
        assign w_pay[k] = (5'(k) < r_s1_cnt) ? w_rdata[k] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_take && w_emit.valid) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_emit.valid) begin
            r_s1_ok  <= w_emit.sum_ok;
            r_s1_cnt <= w_emit.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_o_ok  <= r_s1_ok;
            r_o_cnt <= r_s1_cnt;
            for (int k = 0; k < sfd_pkg::OUT_PAY; k++) begin
                r_o_pay[k] <= w_pay[k];
            end
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.payload_count = r_o_cnt[3:0];
    assign o_res.sum_ok        = r_o_ok;
    assign o_res.pay0          = r_o_pay[0];
    assign o_res.pay1          = r_o_pay[1];
    assign o_res.pay2          = r_o_pay[2];
    assign o_res.pay3          = r_o_pay[3];
    assign o_res.pay4          = r_o_pay[4];
    assign o_res.pay5          = r_o_pay[5];
    assign o_res.pay6          = r_o_pay[6];
    assign o_res.pay7          = r_o_pay[7];

`ifndef SYNTHESIS
    // a completed frame always lands in the holding stage
    a_emit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_emit.valid |=> r_s1_valid)
        else $error("completed frame not captured");

    // a stalled holding stage keeps its result
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_out_free |=> r_s1_valid && $stable(r_s1_cnt) && $stable(r_s1_ok))
        else $error("holding stage lost its result");

    // every frame carries at least one payload byte
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_o_cnt != '0)
        else $error("result with empty payload");
`endif

endmodule

`default_nettype wire
